@@ rtl/core/asls_pkg.sv @@
// asls_pkg: widths, codes, beat types and reset values of the status LED sequencer
// no dependencies; used by alert_status_led_sequencer
package asls_pkg;

    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 8;
    localparam int LEVEL_W   = 8;
    localparam int BLINK_W   = 12;
    localparam int TIMEOUT_W = 20;

    localparam int BREATH_HALF_MS = 900;
    localparam int BREATH_PH_W    = $clog2(2 * BREATH_HALF_MS);
    localparam int UP_W           = $clog2(BREATH_HALF_MS + 1);

    // divide by the half period as a multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT  = 29;
    localparam int BREATH_RECIP = ((2 ** RECIP_SHIFT) + BREATH_HALF_MS - 1) / BREATH_HALF_MS;
    localparam int RECIP_W      = $clog2(BREATH_RECIP + 1);
    localparam int SPAN_M_W     = LEVEL_W + RECIP_W;
    localparam int PROD_W       = UP_W + SPAN_M_W;

    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WORK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONFIRM = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACK_LEVEL    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BREATH_MIN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BREATH_SPAN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LOW   = 3'd5;

    localparam logic [BLINK_W-1:0]   BLINK_PERIOD_RESET = 12'd240;
    localparam logic [BLINK_W-1:0]   BLINK_PERIOD_MIN   = 12'd2;
    localparam logic [LEVEL_W-1:0]   ACK_LEVEL_RESET    = 8'd40;
    localparam logic [LEVEL_W-1:0]   BREATH_MIN_RESET   = 8'd12;
    localparam int                   BREATH_SPAN_RESET  = 170;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET      = 20'd60000;
    localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX        = '1;
    localparam logic [LEVEL_W-1:0]   LEVEL_FULL         = '1;
    localparam logic [COUNT_W-1:0]   COUNT_RESET        = 8'd1;
    localparam logic [COUNT_W-1:0]   BADGE_MIN          = 8'd2;

    localparam logic [SPAN_M_W-1:0] BREATH_SPAN_M_RESET =
        SPAN_M_W'(BREATH_SPAN_RESET * BREATH_RECIP);

    typedef struct packed {
        logic               operation;
        logic [MODE_W-1:0]  mode_code;
        logic [COUNT_W-1:0] session_total;
        logic               button_level;
    } in_beat_t;

    typedef struct packed {
        logic [MODE_W-1:0]  shown_mode;
        logic               panel_on;
        logic               panel_invert;
        logic [COUNT_W-1:0] badge_value;
        logic               alert_acked;
        logic               alert_armed;
        logic [LEVEL_W-1:0] led_duty;
    } out_beat_t;

endpackage

@@ rtl/core/alert_status_led_sequencer.sv @@
// alert_status_led_sequencer: three-mode status indicator with alert, blink and breathing LED
// depends on asls_pkg
//
// Takes one beat (tick or status update) in every clock cycle while s_ready is high and returns one result beat
// per input beat, in order. A result is valid in the cycle after acceptance when the output
// register is free, and later while m_ready holds it back. All status registers update in the
// cycle the beat is accepted, so back-to-back beats see each other's effect without gaps.
// The result goes through an output register backed by a skid register, so s_ready only
// drops once two results wait on m_ready. The breathing level is one 10x28 multiply by a
// reciprocal of the half period taken from a scaled span register set at configuration
// time. Configuration registers sit on an APB port at byte addresses 4*i, pready is
// always high, and writes must only happen while no result is outstanding.
module alert_status_led_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  asls_pkg::in_beat_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output asls_pkg::out_beat_t            m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [asls_pkg::PADDR_W-1:0]   paddr,
    input  logic [asls_pkg::DATA_W-1:0]    pwdata,
    output logic [asls_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    // configuration
    logic [asls_pkg::BLINK_W-1:0]   blink_period_reg;
    logic [asls_pkg::LEVEL_W-1:0]   ack_level_reg;
    logic [asls_pkg::LEVEL_W-1:0]   breath_min_reg;
    logic [asls_pkg::LEVEL_W-1:0]   breath_span_reg;
    logic [asls_pkg::SPAN_M_W-1:0]  span_m_reg;
    logic [asls_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                           active_low_reg;

    // status
    logic [asls_pkg::MODE_W-1:0]      mode_reg, mode_next;
    logic [asls_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                             acked_reg, acked_next;
    logic                             armed_reg, armed_next;
    logic [asls_pkg::BLINK_W-1:0]     blink_phase_reg, blink_phase_next;
    logic [asls_pkg::TIMEOUT_W-1:0]   elapsed_reg, elapsed_next;
    logic [asls_pkg::BREATH_PH_W-1:0] breath_phase_reg, breath_phase_next;
    logic                             prev_button_reg, prev_button_next;

    // output side
    logic                m_valid_reg, skid_valid_reg;
    asls_pkg::out_beat_t m_data_reg, skid_data_reg, result;

    logic                           cfg_write;
    logic [asls_pkg::REG_IDX_W-1:0] cfg_idx;
    logic                           in_accept, out_free;

    logic [asls_pkg::MODE_W-1:0]  new_mode;
    logic [asls_pkg::COUNT_W-1:0] new_count;
    logic                         changed, rearm, calm;

    logic [asls_pkg::BLINK_W-1:0]     eff_period, view_blink;
    logic [asls_pkg::BLINK_W:0]       blink_inc;
    logic [asls_pkg::BLINK_W-1:0]     blink_adv;
    logic [asls_pkg::BREATH_PH_W:0]   breath_inc;
    logic [asls_pkg::BREATH_PH_W-1:0] breath_adv, breath_down;
    logic                             bright;

    logic [asls_pkg::UP_W-1:0]    ramp_up;
    logic [asls_pkg::PROD_W-1:0]  ramp_prod;
    logic [asls_pkg::LEVEL_W-1:0] ramp_q;
    logic [asls_pkg::LEVEL_W:0]   breath_sum;
    logic [asls_pkg::LEVEL_W-1:0] breath_level, level;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[asls_pkg::PADDR_W-1:2];

    assign s_ready   = !skid_valid_reg;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        case (cfg_idx)
            asls_pkg::REG_BLINK_PERIOD: prdata = asls_pkg::DATA_W'(blink_period_reg);
            asls_pkg::REG_ACK_LEVEL:    prdata = asls_pkg::DATA_W'(ack_level_reg);
            asls_pkg::REG_BREATH_MIN:   prdata = asls_pkg::DATA_W'(breath_min_reg);
            asls_pkg::REG_BREATH_SPAN:  prdata = asls_pkg::DATA_W'(breath_span_reg);
            asls_pkg::REG_TIMEOUT:      prdata = asls_pkg::DATA_W'(timeout_reg);
            asls_pkg::REG_ACTIVE_LOW:   prdata = asls_pkg::DATA_W'(active_low_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_period_reg <= asls_pkg::BLINK_PERIOD_RESET;
            ack_level_reg    <= asls_pkg::ACK_LEVEL_RESET;
            breath_min_reg   <= asls_pkg::BREATH_MIN_RESET;
            breath_span_reg  <= asls_pkg::LEVEL_W'(asls_pkg::BREATH_SPAN_RESET);
            span_m_reg       <= asls_pkg::BREATH_SPAN_M_RESET;
            timeout_reg      <= asls_pkg::TIMEOUT_RESET;
            active_low_reg   <= 1'b1;
        end else if (cfg_write) begin
            case (cfg_idx)
                asls_pkg::REG_BLINK_PERIOD: blink_period_reg <= pwdata[asls_pkg::BLINK_W-1:0];
                asls_pkg::REG_ACK_LEVEL:    ack_level_reg <= pwdata[asls_pkg::LEVEL_W-1:0];
                asls_pkg::REG_BREATH_MIN:   breath_min_reg <= pwdata[asls_pkg::LEVEL_W-1:0];
                asls_pkg::REG_BREATH_SPAN: begin
                    breath_span_reg <= pwdata[asls_pkg::LEVEL_W-1:0];
                    span_m_reg      <= asls_pkg::SPAN_M_W'(pwdata[asls_pkg::LEVEL_W-1:0])
                                       * asls_pkg::SPAN_M_W'(asls_pkg::BREATH_RECIP);
                end
                asls_pkg::REG_TIMEOUT:      timeout_reg <= pwdata[asls_pkg::TIMEOUT_W-1:0];
                asls_pkg::REG_ACTIVE_LOW:   active_low_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // update decode
    assign new_mode  = (s_data.mode_code == asls_pkg::MODE_UNKNOWN) ? asls_pkg::MODE_OFF
                                                                    : s_data.mode_code;
    assign new_count = (s_data.session_total == '0) ? asls_pkg::COUNT_RESET
                                                    : s_data.session_total;
    assign changed   = !(new_mode == mode_reg && new_count == count_reg);
    assign rearm     = (new_mode != mode_reg) || (new_count > count_reg);

    // tick decode
    assign calm = (prev_button_reg && !s_data.button_level)
                  || (armed_reg && (elapsed_reg > timeout_reg));

    assign eff_period  = (blink_period_reg < asls_pkg::BLINK_PERIOD_MIN)
                         ? asls_pkg::BLINK_PERIOD_MIN : blink_period_reg;
    assign blink_inc   = {1'b0, blink_phase_reg} + 1'b1;
    assign blink_adv   = (blink_inc >= {1'b0, eff_period}) ? '0
                                                           : blink_inc[asls_pkg::BLINK_W-1:0];
    assign breath_inc  = {1'b0, breath_phase_reg} + 1'b1;
    assign breath_adv  = (breath_inc >= (asls_pkg::BREATH_PH_W + 1)'(2 * asls_pkg::BREATH_HALF_MS))
                         ? '0 : breath_inc[asls_pkg::BREATH_PH_W-1:0];

    always_comb begin
        mode_next         = mode_reg;
        count_next        = count_reg;
        acked_next        = acked_reg;
        armed_next        = armed_reg;
        blink_phase_next  = blink_phase_reg;
        elapsed_next      = elapsed_reg;
        breath_phase_next = breath_phase_reg;
        prev_button_next  = prev_button_reg;
        if (in_accept) begin
            if (s_data.operation == asls_pkg::OP_UPDATE) begin
                if (changed) begin
                    mode_next  = new_mode;
                    count_next = new_count;
                    if (new_mode == asls_pkg::MODE_CONFIRM) begin
                        if (rearm) begin
                            acked_next       = 1'b0;
                            armed_next       = 1'b1;
                            blink_phase_next = '0;
                            elapsed_next     = '0;
                        end
                    end else begin
                        armed_next = 1'b0;
                    end
                end
            end else begin
                prev_button_next = s_data.button_level;
                if (calm) begin
                    acked_next = 1'b1;
                    armed_next = 1'b0;
                end
                blink_phase_next  = blink_adv;
                breath_phase_next = breath_adv;
                if (elapsed_reg != asls_pkg::ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= asls_pkg::MODE_OFF;
            count_reg        <= asls_pkg::COUNT_RESET;
            acked_reg        <= 1'b0;
            armed_reg        <= 1'b0;
            blink_phase_reg  <= '0;
            elapsed_reg      <= '0;
            breath_phase_reg <= '0;
            prev_button_reg  <= 1'b1;
        end else begin
            mode_reg         <= mode_next;
            count_reg        <= count_next;
            acked_reg        <= acked_next;
            armed_reg        <= armed_next;
            blink_phase_reg  <= blink_phase_next;
            elapsed_reg      <= elapsed_next;
            breath_phase_reg <= breath_phase_next;
            prev_button_reg  <= prev_button_next;
        end
    end

    // a tick shows the phases before they advance, an update after a possible restart
    assign view_blink = (s_data.operation == asls_pkg::OP_UPDATE) ? blink_phase_next
                                                                  : blink_phase_reg;
    assign bright     = view_blink < (eff_period >> 1);

    // breathing ramp: min + up * span / half, saturating
    assign breath_down = asls_pkg::BREATH_PH_W'(2 * asls_pkg::BREATH_HALF_MS) - breath_phase_reg;
    assign ramp_up     = (breath_phase_reg < asls_pkg::BREATH_PH_W'(asls_pkg::BREATH_HALF_MS))
                         ? asls_pkg::UP_W'(breath_phase_reg) : asls_pkg::UP_W'(breath_down);
    assign ramp_prod   = asls_pkg::PROD_W'(ramp_up) * asls_pkg::PROD_W'(span_m_reg);
    assign ramp_q      = ramp_prod[asls_pkg::RECIP_SHIFT +: asls_pkg::LEVEL_W];
    assign breath_sum  = {1'b0, breath_min_reg} + {1'b0, ramp_q};
    assign breath_level = breath_sum[asls_pkg::LEVEL_W] ? asls_pkg::LEVEL_FULL
                                                        : breath_sum[asls_pkg::LEVEL_W-1:0];

    always_comb begin
        case (mode_next)
            asls_pkg::MODE_CONFIRM: begin
                if (acked_next) begin
                    level = ack_level_reg;
                end else begin
                    level = bright ? asls_pkg::LEVEL_FULL : '0;
                end
            end
            asls_pkg::MODE_WORK: level = breath_level;
            default:             level = '0;
        endcase
    end

    always_comb begin
        result.shown_mode   = mode_next;
        result.panel_on     = (mode_next == asls_pkg::MODE_WORK)
                              || (mode_next == asls_pkg::MODE_CONFIRM);
        result.panel_invert = (mode_next == asls_pkg::MODE_CONFIRM) && !acked_next && bright;
        result.badge_value  = (count_next >= asls_pkg::BADGE_MIN) ? count_next : '0;
        result.alert_acked  = acked_next;
        result.alert_armed  = armed_next;
        result.led_duty     = active_low_reg ? ~level : level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg    <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end else if (in_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (in_accept) begin
            skid_data_reg <= result;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid beat held while output register empty");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && m_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("accepted beat under stall not parked in skid");

    a_armed_in_confirm: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |-> (mode_reg == asls_pkg::MODE_CONFIRM))
        else $error("alert armed outside confirm mode");

    a_armed_not_acked: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |-> !acked_reg)
        else $error("alert armed and acknowledged at once");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0)
        else $error("session count dropped to zero");

endmodule

@@ tb/status_led_checker.sv @@
// status_led_checker: predicts and checks every result beat of the status LED sequencer
// tracks register writes on the apb port; depends on asls_pkg
module status_led_checker import asls_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_beat_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_beat_t            m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output int                   errors,
    output int                   pending,
    output int                   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BREATH_WRAP = 2 * BREATH_HALF_MS;

    logic [BLINK_W-1:0]     period_cfg;
    logic [LEVEL_W-1:0]     ack_cfg;
    logic [LEVEL_W-1:0]     floor_cfg;
    logic [LEVEL_W-1:0]     span_cfg;
    logic [TIMEOUT_W-1:0]   timeout_cfg;
    logic                   invert_cfg;

    logic [MODE_W-1:0]      mode_now;
    logic [COUNT_W-1:0]     count_now;
    logic                   acked_now;
    logic                   armed_now;
    logic                   btn_last;
    logic [BLINK_W-1:0]     blink_ph;
    logic [TIMEOUT_W-1:0]   elapsed;
    logic [BREATH_PH_W-1:0] breath_ph;

    out_beat_t expected_status[$];
    int        err_tally  = 0;
    int        beat_tally = 0;

    function automatic int blink_len();
        return (period_cfg < BLINK_PERIOD_MIN) ? int'(BLINK_PERIOD_MIN) : int'(period_cfg);
    endfunction

    function automatic out_beat_t status_now();
        out_beat_t r;
        int        up;
        int        lvl;
        logic      bright;
        bright = int'(blink_ph) < blink_len() / 2;
        lvl = 0;
        if (mode_now == MODE_CONFIRM) begin
            lvl = acked_now ? int'(ack_cfg) : (bright ? int'(LEVEL_FULL) : 0);
        end else if (mode_now == MODE_WORK) begin
            up = (int'(breath_ph) < BREATH_HALF_MS) ? int'(breath_ph)
                                                    : BREATH_WRAP - int'(breath_ph);
            lvl = int'(floor_cfg) + up * int'(span_cfg) / BREATH_HALF_MS;
            if (lvl > int'(LEVEL_FULL)) lvl = int'(LEVEL_FULL);
        end
        r.shown_mode   = mode_now;
        r.panel_on     = (mode_now == MODE_WORK) || (mode_now == MODE_CONFIRM);
        r.panel_invert = (mode_now == MODE_CONFIRM) && !acked_now && bright;
        r.badge_value  = (count_now >= BADGE_MIN) ? count_now : '0;
        r.alert_acked  = acked_now;
        r.alert_armed  = armed_now;
        r.led_duty     = invert_cfg ? LEVEL_FULL - LEVEL_W'(lvl) : LEVEL_W'(lvl);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_tally++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        in_beat_t          b;
        out_beat_t         want;
        logic [MODE_W-1:0] new_mode;
        logic [COUNT_W-1:0] new_count;
        logic              rearm;
        if (!aresetn) begin
            period_cfg  = BLINK_PERIOD_RESET;
            ack_cfg     = ACK_LEVEL_RESET;
            floor_cfg   = BREATH_MIN_RESET;
            span_cfg    = LEVEL_W'(BREATH_SPAN_RESET);
            timeout_cfg = TIMEOUT_RESET;
            invert_cfg  = 1'b1;
            mode_now    = MODE_OFF;
            count_now   = COUNT_RESET;
            acked_now   = 1'b0;
            armed_now   = 1'b0;
            btn_last    = 1'b1;
            blink_ph    = '0;
            elapsed     = '0;
            breath_ph   = '0;
            expected_status.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    err_tally++;
                    $display("%0t ns: result beat with none expected, actual %h", $time, m_data);
                end else begin
                    want = expected_status.pop_front();
                    check_field("shown_mode", 32'(want.shown_mode), 32'(m_data.shown_mode));
                    check_field("panel_on", 32'(want.panel_on), 32'(m_data.panel_on));
                    check_field("panel_invert", 32'(want.panel_invert),
                                32'(m_data.panel_invert));
                    check_field("badge_value", 32'(want.badge_value), 32'(m_data.badge_value));
                    check_field("alert_acked", 32'(want.alert_acked), 32'(m_data.alert_acked));
                    check_field("alert_armed", 32'(want.alert_armed), 32'(m_data.alert_armed));
                    check_field("led_duty", 32'(want.led_duty), 32'(m_data.led_duty));
                    beat_tally++;
                end
            end

            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_BLINK_PERIOD: period_cfg  = pwdata[BLINK_W-1:0];
                    REG_ACK_LEVEL:    ack_cfg     = pwdata[LEVEL_W-1:0];
                    REG_BREATH_MIN:   floor_cfg   = pwdata[LEVEL_W-1:0];
                    REG_BREATH_SPAN:  span_cfg    = pwdata[LEVEL_W-1:0];
                    REG_TIMEOUT:      timeout_cfg = pwdata[TIMEOUT_W-1:0];
                    REG_ACTIVE_LOW:   invert_cfg  = pwdata[0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                b = s_data;
                if (b.operation == OP_UPDATE) begin
                    new_mode  = (b.mode_code == MODE_UNKNOWN) ? MODE_OFF : b.mode_code;
                    new_count = (b.session_total == '0) ? COUNT_RESET : b.session_total;
                    if (!(new_mode == mode_now && new_count == count_now)) begin
                        rearm     = (new_mode != mode_now) || (new_count > count_now);
                        mode_now  = new_mode;
                        count_now = new_count;
                        if (new_mode == MODE_CONFIRM) begin
                            if (rearm) begin
                                acked_now = 1'b0;
                                armed_now = 1'b1;
                                blink_ph  = '0;
                                elapsed   = '0;
                            end
                        end else begin
                            armed_now = 1'b0;
                        end
                    end
                    expected_status.push_back(status_now());
                end else begin
                    // falling button edge, then timeout, both acknowledge
                    if (btn_last && !b.button_level) begin
                        acked_now = 1'b1;
                        armed_now = 1'b0;
                    end
                    btn_last = b.button_level;
                    if (armed_now && elapsed > timeout_cfg) begin
                        acked_now = 1'b1;
                        armed_now = 1'b0;
                    end
                    expected_status.push_back(status_now());
                    blink_ph  = (int'(blink_ph) + 1 >= blink_len()) ? '0 : blink_ph + 1'b1;
                    breath_ph = (int'(breath_ph) + 1 >= BREATH_WRAP) ? '0 : breath_ph + 1'b1;
                    if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
                end
            end
        end
        errors  <= err_tally;
        pending <= expected_status.size();
        checked <= beat_tally;
    end

endmodule

@@ tb/testbench.sv @@
// testbench: stimulus and verdict for alert_status_led_sequencer
// drives ticks, updates and apb register writes; checking is done in status_led_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import asls_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_beat_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_beat_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int errors;
    int pending;
    int checked;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    logic               btn_hold  = 1'b1;
    logic [MODE_W-1:0]  upd_mode  = MODE_OFF;
    logic [COUNT_W-1:0] upd_total = COUNT_RESET;

    alert_status_led_sequencer DUT (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    status_led_checker u_check (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .errors, .pending, .checked
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_beat(input in_beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly ticks with a slowly toggling button, updates biased toward confirm alerts
    task automatic run_random(input int count);
        in_beat_t b;
        int       pick;
        repeat (count) begin
            b.mode_code     = MODE_W'($urandom_range(3));
            b.session_total = COUNT_W'($urandom_range(255));
            b.button_level  = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 16) begin
                b.operation = OP_UPDATE;
                if (pick < 5) begin
                    b.mode_code     = upd_mode;
                    b.session_total = upd_total;
                end else if (pick < 11) begin
                    b.mode_code = MODE_CONFIRM;
                    if (pick < 9) begin
                        b.session_total = upd_total + COUNT_W'($urandom_range(2)) - 1'b1;
                    end
                end else if (pick < 13) begin
                    b.mode_code     = MODE_WORK;
                    b.session_total = COUNT_W'($urandom_range(3));
                end
                upd_mode  = b.mode_code;
                upd_total = b.session_total;
            end else begin
                b.operation = OP_TICK;
                if ($urandom_range(99) < 2) btn_hold = !btn_hold;
                if ($urandom_range(9) != 0) b.button_level = btn_hold;
            end
            send_beat(b);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, writes past the register list must be ignored
        send_idle_pct = 23;
        recv_idle_pct = 56;
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_WORK,    8'd0,   1'b1});
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b1});
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_WORK,    8'd255, 1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_CONFIRM, 8'd255, 1'b1});
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b1});
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b0});
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b0});
        send_beat(in_beat_t'{OP_UPDATE, MODE_CONFIRM, 8'd255, 1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_CONFIRM, 8'd3,   1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_CONFIRM, 8'd200, 1'b1});
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b1});
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_UNKNOWN, 8'd2,   1'b1});
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b0});
        send_beat(in_beat_t'{OP_TICK,   MODE_OFF,     8'd0,   1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_WORK,    8'd2,   1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_CONFIRM, 8'd1,   1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_OFF,     8'd1,   1'b1});
        send_beat(in_beat_t'{OP_TICK,   MODE_UNKNOWN, 8'hAA,  1'b1});
        send_beat(in_beat_t'{OP_UPDATE, MODE_CONFIRM, 8'd128, 1'b0});
        send_beat(in_beat_t'{OP_TICK,   MODE_CONFIRM, 8'h55,  1'b1});
        run_random(380);
        drain();

        // low extremes: shortest blink, immediate timeout, saturating ramp, no inversion
        send_idle_pct = 56;
        recv_idle_pct = 23;
        write_reg(REG_BLINK_PERIOD, 32'd0);
        write_reg(REG_ACK_LEVEL,    32'd255);
        write_reg(REG_BREATH_MIN,   32'd255);
        write_reg(REG_BREATH_SPAN,  32'd255);
        write_reg(REG_TIMEOUT,      32'd0);
        write_reg(REG_ACTIVE_LOW,   32'd0);
        run_random(400);
        drain();

        // high extremes: longest blink, timeout that never fires, flat dark ramp
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_BLINK_PERIOD, 32'(12'hFFF));
        write_reg(REG_ACK_LEVEL,    32'd0);
        write_reg(REG_BREATH_MIN,   32'd0);
        write_reg(REG_BREATH_SPAN,  32'd0);
        write_reg(REG_TIMEOUT,      32'(ELAPSED_MAX));
        write_reg(REG_ACTIVE_LOW,   32'd1);
        run_random(400);
        drain();

        // short random period after a long one, small timeouts
        write_reg(REG_BLINK_PERIOD, 32'($urandom_range(1, 12)));
        write_reg(REG_ACK_LEVEL,    32'($urandom_range(255)));
        write_reg(REG_BREATH_MIN,   32'($urandom_range(100)));
        write_reg(REG_BREATH_SPAN,  32'($urandom_range(255)));
        write_reg(REG_TIMEOUT,      32'($urandom_range(40)));
        write_reg(REG_ACTIVE_LOW,   32'($urandom_range(1)));
        run_random(450);
        drain();

        $display("run covered %0d input beats across four register settings and three stall mixes",
                 items_sent);
        $display("%0d result beats compared, %0d field mismatches", checked, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
